FILE: rtl/core/srxl2fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxl2fr_pkg
// Shared types and constants for the link frame responder.
// ----------------------------------------------------------------------------
package srxl2fr_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SENSOR_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE_TYPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TYPE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MASK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 3'd6;

    localparam logic [7:0]  RST_DEVICE_ID      = 8'd49;
    localparam logic [7:0]  RST_HEADER_CODE    = 8'd166;
    localparam logic [7:0]  RST_HANDSHAKE_TYPE = 8'd33;
    localparam logic [7:0]  RST_CONTROL_TYPE   = 8'd205;
    localparam logic [7:0]  RST_SENSOR_MASK    = 8'd0;
    localparam logic [7:0]  RST_BAD_LIMIT      = 8'd50;
    localparam logic [15:0] RST_TIMEOUT        = 16'd50;

    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_HANDSHAKE = 2'd1;
    localparam logic [1:0] ACT_TELEMETRY = 2'd2;
    localparam logic [1:0] ACT_SPEED     = 2'd3;

    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [7:0] BROADCAST_ID = 8'hFF;
    localparam logic [7:0] NO_PARTNER   = 8'hFF;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd3;
    localparam logic [7:0] SHORT_FRAME_LEN = 8'd1;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [7:0]  header_code;
        logic [7:0]  handshake_type;
        logic [7:0]  control_type;
        logic [7:0]  sensor_enable_mask;
        logic [7:0]  bad_frame_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                found;
        logic [SENSOR_W-1:0] index;
        logic [SENSOR_W-1:0] next_pointer;
    } pick_t;

endpackage

FILE: rtl/core/srxl2fr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxl2fr_cfg_regs
// Configuration register file with reset defaults, write only.
// ----------------------------------------------------------------------------
module srxl2fr_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [srxl2fr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srxl2fr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output srxl2fr_pkg::cfg_t                    cfg
);
    import srxl2fr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id          <= RST_DEVICE_ID;
            cfg_reg.header_code        <= RST_HEADER_CODE;
            cfg_reg.handshake_type     <= RST_HANDSHAKE_TYPE;
            cfg_reg.control_type       <= RST_CONTROL_TYPE;
            cfg_reg.sensor_enable_mask <= RST_SENSOR_MASK;
            cfg_reg.bad_frame_limit    <= RST_BAD_LIMIT;
            cfg_reg.timeout_ticks      <= RST_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEVICE_ID:      cfg_reg.device_id          <= cfg_data[7:0];
                REG_HEADER_CODE:    cfg_reg.header_code        <= cfg_data[7:0];
                REG_HANDSHAKE_TYPE: cfg_reg.handshake_type     <= cfg_data[7:0];
                REG_CONTROL_TYPE:   cfg_reg.control_type       <= cfg_data[7:0];
                REG_SENSOR_MASK:    cfg_reg.sensor_enable_mask <= cfg_data[7:0];
                REG_BAD_LIMIT:      cfg_reg.bad_frame_limit    <= cfg_data[7:0];
                REG_TIMEOUT:        cfg_reg.timeout_ticks      <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/srxl2fr_sensor_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxl2fr_sensor_pick
// Round-robin pick of the next enabled sensor starting at the pointer.
// ----------------------------------------------------------------------------
module srxl2fr_sensor_pick
#(
    parameter int unsigned SENSOR_KINDS = 8
)
(
    input  logic [7:0]                          mask,
    input  logic [srxl2fr_pkg::SENSOR_W-1:0]    pointer,
    output srxl2fr_pkg::pick_t                  pick
);
    import srxl2fr_pkg::*;

    localparam logic [SENSOR_W:0] KINDS = (SENSOR_W+1)'(SENSOR_KINDS);

    logic [SENSOR_W-1:0] start;
    logic [SENSOR_W:0]   last_plus;

    always_comb
    begin
        logic [SENSOR_W:0] idx;
        start = ({1'b0, pointer} >= KINDS) ? '0 : pointer;
        pick.found = 1'b0;
        pick.index = '0;
        for (int k = 0; k < 8; k++)
        begin
            idx = {1'b0, start} + (SENSOR_W+1)'(k);
            if (idx >= KINDS)
            begin
                idx = idx - KINDS;
            end
            if ((k < int'(SENSOR_KINDS)) && !pick.found && mask[idx[SENSOR_W-1:0]])
            begin
                pick.found = 1'b1;
                pick.index = idx[SENSOR_W-1:0];
            end
        end
        last_plus = {1'b0, pick.index} + (SENSOR_W+1)'(1);
        pick.next_pointer = (last_plus >= KINDS) ? '0 : last_plus[SENSOR_W-1:0];
    end

endmodule

FILE: rtl/core/srxl2_frame_responder_core.sv
`timescale 1ns / 1ps
// Stages: input register, decision logic, output register; a result is valid once
// its word has passed both. Throughput: one word per cycle unless out_stall holds.
// Reset: partner cleared to none, speed slow, counters and sensor pointer zero,
// configuration registers at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// srxl2_frame_responder_core
// Device-side link responder: frame and tick handling, speed and telemetry.
// ----------------------------------------------------------------------------
module srxl2_frame_responder_core
#(
    parameter int unsigned SENSOR_KINDS  = 8,
    parameter int unsigned MAX_FRAME_LEN = 128
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [srxl2fr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srxl2fr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [7:0]                           frame_length,
    input  logic [7:0]                           first_byte,
    input  logic [7:0]                           type_byte,
    input  logic [7:0]                           source_byte,
    input  logic [7:0]                           dest_byte,
    input  logic [7:0]                           speed_byte,
    input  logic                                 check_ok,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           action,
    output logic [7:0]                           reply_dest,
    output logic [2:0]                           sensor_index,
    output logic                                 speed_fast,
    output logic [7:0]                           bad_count
);
    import srxl2fr_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LEN);

    cfg_t  cfg;
    pick_t pick;

    // input stage
    logic       s1_valid_reg;
    logic       s1_func_reg;
    logic [7:0] s1_len_reg;
    logic [7:0] s1_first_reg;
    logic [7:0] s1_type_reg;
    logic [7:0] s1_src_reg;
    logic [7:0] s1_dest_reg;
    logic [7:0] s1_speed_reg;
    logic       s1_chk_reg;

    // state
    logic [7:0]          partner_reg,  partner_next;
    logic                fast_reg,     fast_next;
    logic [7:0]          bad_reg,      bad_next;
    logic [SENSOR_W-1:0] pointer_reg,  pointer_next;
    logic [15:0]         silence_reg,  silence_next;

    // output stage
    logic                out_valid_reg;
    logic [1:0]          action_reg,   action_next;
    logic [7:0]          dest_reg,     dest_next;
    logic [SENSOR_W-1:0] sidx_reg,     sidx_next;

    logic advance;
    logic s1_take;
    logic in_take;
    logic [15:0] silence_inc;
    logic is_hdr;
    logic hs_me;
    logic ctl_me;
    logic hs_bcast;
    logic [7:0] bad_inc;

    srxl2fr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srxl2fr_sensor_pick #(.SENSOR_KINDS(SENSOR_KINDS)) u_pick
    (
        .mask    (cfg.sensor_enable_mask),
        .pointer (pointer_reg),
        .pick    (pick)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign s1_take  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg  <= func;
            s1_len_reg   <= frame_length;
            s1_first_reg <= first_byte;
            s1_type_reg  <= type_byte;
            s1_src_reg   <= source_byte;
            s1_dest_reg  <= dest_byte;
            s1_speed_reg <= speed_byte;
            s1_chk_reg   <= check_ok;
        end
    end

    assign silence_inc = (silence_reg == 16'hFFFF) ? silence_reg : silence_reg + 16'd1;
    assign bad_inc     = (bad_reg == 8'hFF) ? bad_reg : bad_reg + 8'd1;
    assign is_hdr      = (s1_first_reg == cfg.header_code);
    assign hs_me       = is_hdr && (s1_type_reg == cfg.handshake_type)
                         && (s1_dest_reg == cfg.device_id);
    assign ctl_me      = is_hdr && (s1_type_reg == cfg.control_type)
                         && (s1_dest_reg == cfg.device_id);
    assign hs_bcast    = is_hdr && (s1_type_reg == cfg.handshake_type)
                         && (s1_dest_reg == BROADCAST_ID);

    always_comb
    begin
        partner_next = partner_reg;
        fast_next    = fast_reg;
        bad_next     = bad_reg;
        pointer_next = pointer_reg;
        silence_next = silence_reg;
        action_next  = ACT_NONE;
        dest_next    = '0;
        sidx_next    = '0;
        if (s1_func_reg == FUNC_TICK)
        begin
            silence_next = silence_inc;
            if (silence_inc >= cfg.timeout_ticks)
            begin
                silence_next = '0;
                fast_next    = 1'b0;
                action_next  = ACT_HANDSHAKE;
            end
        end
        else if (s1_len_reg != '0)
        begin
            silence_next = '0;
            priority if (bad_reg > cfg.bad_frame_limit)
            begin
                fast_next   = !fast_reg;
                bad_next    = '0;
                action_next = ACT_SPEED;
            end
            else if ((s1_len_reg < MIN_FRAME_LEN) || (s1_len_reg > MAX_LEN))
            begin
                if (s1_len_reg != SHORT_FRAME_LEN)
                begin
                    bad_next = bad_inc;
                end
            end
            else if (!s1_chk_reg && ((partner_reg != NO_PARTNER) || !hs_me))
            begin
                bad_next = bad_inc;
            end
            else
            begin
                bad_next = '0;
                priority if (hs_me)
                begin
                    partner_next = s1_src_reg;
                    action_next  = ACT_HANDSHAKE;
                    dest_next    = s1_src_reg;
                end
                else if (ctl_me)
                begin
                    if (pick.found)
                    begin
                        action_next  = ACT_TELEMETRY;
                        dest_next    = partner_reg;
                        sidx_next    = pick.index;
                        pointer_next = pick.next_pointer;
                    end
                end
                else if (hs_bcast)
                begin
                    fast_next   = (s1_speed_reg != '0);
                    action_next = ACT_SPEED;
                end
                else
                begin
                    action_next = ACT_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partner_reg   <= NO_PARTNER;
            fast_reg      <= 1'b0;
            bad_reg       <= '0;
            pointer_reg   <= '0;
            silence_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                partner_reg <= partner_next;
                fast_reg    <= fast_next;
                bad_reg     <= bad_next;
                pointer_reg <= pointer_next;
                silence_reg <= silence_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    logic       speed_out_reg;
    logic [7:0] bad_out_reg;

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            action_reg    <= action_next;
            dest_reg      <= dest_next;
            sidx_reg      <= sidx_next;
            speed_out_reg <= fast_next;
            bad_out_reg   <= bad_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign reply_dest   = dest_reg;
    assign sensor_index = sidx_reg;
    assign speed_fast   = speed_out_reg;
    assign bad_count    = bad_out_reg;

endmodule
